[design/umsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the USB-MIDI SysEx packetizer.
// No dependencies.
package umsp_pkg;

    localparam int UMSP_MAX_PAYLOAD = 4096;
    localparam int UMSP_CFG_W       = 13;
    localparam int UMSP_JOB_BYTES   = 5;
    localparam int UMSP_QDEPTH      = 2;

    localparam logic [UMSP_CFG_W-1:0] UMSP_LEN_RST = 13'd64;

    // USB-MIDI code index numbers and SysEx framing bytes
    localparam logic [7:0] HDR_CONT = 8'h04;
    localparam logic [7:0] HDR_END1 = 8'h05;
    localparam logic [7:0] HDR_END2 = 8'h06;
    localparam logic [7:0] HDR_END3 = 8'h07;
    localparam logic [7:0] BYTE_SOX = 8'hF0;
    localparam logic [7:0] BYTE_EOX = 8'hF7;
    localparam logic [7:0] BYTE_PAD = 8'h00;

    // One request's worth of stream bytes, built by the front end
    typedef struct packed {
        logic [UMSP_JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                     count;
        logic                           msg_end;
    } t_job;

endpackage
`default_nettype wire

[design/umsp_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one SysEx payload byte per request.
// No dependencies.
interface umsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

[design/umsp_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Output channel: one USB-MIDI stream byte per request with framing flags.
// No dependencies.
interface umsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_byte, output run_last, output message_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input message_end,
                    output ready);
endinterface
`default_nettype wire

[design/umsp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front end: length register, message position tracking, and expansion of
// each payload byte into a job of up to five stream bytes. Uses umsp_pkg.
module umsp_front #(
    parameter int MAX_PAYLOAD = umsp_pkg::UMSP_MAX_PAYLOAD
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [umsp_pkg::UMSP_CFG_W-1:0]   i_cfg_wdata,
    umsp_in_if.sink                          i_in,
    output logic                             o_push,
    input  wire                              i_full,
    output umsp_pkg::t_job                   o_job
);
    import umsp_pkg::*;

    localparam int RW = $clog2(MAX_PAYLOAD + 1);
    localparam int LW = (RW > UMSP_CFG_W) ? RW : UMSP_CFG_W;

    logic [UMSP_CFG_W-1:0] r_len;
    logic [RW-1:0]         r_rem, n_rem;
    logic [1:0]            r_slot, n_slot;

    logic [LW-1:0] len_ext, len_clamp;
    logic          start, hdr, fin;
    logic [RW-1:0] rem1;
    logic [1:0]    slot0, slot1, slot_h, slot2, pads;
    logic [7:0]    hdr_val;
    logic [7:0][7:0] seq;
    logic [2:0]    n;
    logic          accept;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept;

    always_comb begin
        len_ext = LW'(r_len);
        if (len_ext < LW'(2)) begin
            len_clamp = LW'(2);
        end else if (len_ext > LW'(MAX_PAYLOAD)) begin
            len_clamp = LW'(MAX_PAYLOAD);
        end else begin
            len_clamp = len_ext;
        end

        start  = (r_rem == '0);
        rem1   = (start ? RW'(len_clamp) : r_rem) - RW'(1);
        slot0  = start ? 2'd2 : r_slot;
        slot1  = slot0 + 2'd1;
        hdr    = (slot1 == 2'd0);
        slot_h = hdr ? 2'd1 : slot1;
        fin    = (rem1 == '0);
        slot2  = slot_h + 2'd1;
        pads   = 2'd0 - slot2;

        if (rem1 == RW'(2)) begin
            hdr_val = HDR_END3;
        end else if (rem1 == RW'(1)) begin
            hdr_val = HDR_END2;
        end else if (rem1 == '0) begin
            hdr_val = HDR_END1;
        end else begin
            hdr_val = HDR_CONT;
        end

        seq = '0;
        n   = 3'd0;
        if (start) begin
            seq[0] = HDR_CONT;
            seq[1] = BYTE_SOX;
            n      = 3'd2;
        end
        seq[n] = i_in.data_byte;
        n      = n + 3'd1;
        if (hdr) begin
            seq[n] = hdr_val;
            n      = n + 3'd1;
        end
        if (fin) begin
            seq[n] = BYTE_EOX;
            n      = n + 3'd1;
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < pads) begin
                    seq[n] = BYTE_PAD;
                    n      = n + 3'd1;
                end
            end
        end

        for (int j = 0; j < UMSP_JOB_BYTES; j++) begin
            o_job.bytes[j] = seq[j];
        end
        o_job.count   = n;
        o_job.msg_end = fin;

        n_rem  = rem1;
        n_slot = fin ? 2'd0 : slot_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= UMSP_LEN_RST;
            r_rem  <= '0;
            r_slot <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_rem  <= n_rem;
                r_slot <= n_slot;
            end
        end
    end

endmodule
`default_nettype wire

[design/umsp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Short job queue between front and back end.
// Uses umsp_pkg for the job type and depth.
module umsp_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  umsp_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    input  wire             i_pop,
    output umsp_pkg::t_job  o_job
);
    import umsp_pkg::*;

    localparam int PW = (UMSP_QDEPTH > 1) ? $clog2(UMSP_QDEPTH) : 1;
    localparam int CW = $clog2(UMSP_QDEPTH + 1);

    t_job          r_mem [UMSP_QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(UMSP_QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(UMSP_QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(UMSP_QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

[design/umsp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back end: walks the head job one byte per cycle into the output register while the receiver accepts.
// Uses umsp_pkg and umsp_out_if.
module umsp_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  umsp_pkg::t_job  i_job,
    output logic            o_pop,
    umsp_out_if.source      o_out
);
    import umsp_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last, r_end;
    logic       load, last;
    logic [7:0] sel;

    assign load  = i_valid && (!r_valid || o_out.ready);
    assign last  = (r_idx == i_job.count - 3'd1);
    assign o_pop = load && last;

    always_comb begin
        case (r_idx)
            3'd0:    sel = i_job.bytes[0];
            3'd1:    sel = i_job.bytes[1];
            3'd2:    sel = i_job.bytes[2];
            3'd3:    sel = i_job.bytes[3];
            3'd4:    sel = i_job.bytes[4];
            default: sel = BYTE_PAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? 3'd0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel;
            r_last <= last;
            r_end  <= last && i_job.msg_end;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.run_last    = r_last;
    assign o_out.message_end = r_end;

endmodule
`default_nettype wire

[design/usb_midi_sysex_packetizer_top.sv]
// USB-MIDI SysEx packetizer.
// i_in carries SysEx payload bytes, one per request, in message order.
// o_out carries the USB-MIDI event stream, one byte per request: the 0x04/0xF0
// opening, data, packet headers, 0xF7 and zero padding. run_last marks the
// last byte caused by an input byte, message_end the final byte of a message.
// i_cfg_we/i_cfg_wdata set the payload length, used when a message starts.
// Each input byte yields 1 to 5 output bytes (about 4/3 on average over a
// long message); the back end sends one output byte per cycle while the
// receiver is ready. The first output byte passes through the queue entry
// and then the output register after the input is accepted.
// A two-entry job queue decouples the sides: input is taken while the queue
// has room, independent of output stalls until the queue fills.
// When the receiver stalls, the output register holds its byte and flags.
// Reset clears the message position, empties the queue and output, and sets
// the payload length to 64.
`timescale 1ns / 1ps
`default_nettype none
module usb_midi_sysex_packetizer_top #(
    parameter int MAX_PAYLOAD = umsp_pkg::UMSP_MAX_PAYLOAD
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [umsp_pkg::UMSP_CFG_W-1:0]   i_cfg_wdata,
    umsp_in_if.sink                          i_in,
    umsp_out_if.source                       o_out
);
    import umsp_pkg::*;

    t_job f_job, q_job;
    logic push, full, q_valid, pop;

    umsp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_push      (push),
        .i_full      (full),
        .o_job       (f_job)
    );

    umsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    umsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[bench/tb_usb_midi_sysex_packetizer_top.sv]
`timescale 1ns / 1ps
// Testbench for usb_midi_sysex_packetizer_top: random payload bytes and lengths,
// bursty sender, stalling receiver, stream checked against a built-in predictor.
// Depends on umsp_pkg, umsp_in_if, umsp_out_if and the packetizer RTL.
module tb_usb_midi_sysex_packetizer_top;
    import umsp_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } t_stream_byte;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} t_rx_mode;

    class sysex_scoreboard;
        logic [UMSP_CFG_W-1:0] length_reg;
        int unsigned           remaining;
        logic [1:0]            slot;
        t_stream_byte          expected_q[$];
        int unsigned           mismatches;

        function new();
            length_reg = UMSP_LEN_RST;
            remaining  = 0;
            slot       = 2'd0;
            mismatches = 0;
        endfunction

        function void set_length(input logic [UMSP_CFG_W-1:0] value);
            length_reg = value;
        endfunction

        // Predicts the stream bytes caused by one accepted payload byte.
        function void note_request(input logic [7:0] data);
            logic [7:0]   run_bytes[$];
            int unsigned  len;
            bit           ended;
            t_stream_byte e;
            ended = 1'b0;
            if (remaining == 0) begin
                len = length_reg;
                if (len < 2)
                    len = 2;
                if (len > UMSP_MAX_PAYLOAD)
                    len = UMSP_MAX_PAYLOAD;
                remaining = len;
                run_bytes.push_back(HDR_CONT);
                run_bytes.push_back(BYTE_SOX);
                slot = 2'd2;
            end
            run_bytes.push_back(data);
            remaining--;
            slot++;
            if (slot == 2'd0) begin
                case (remaining)
                    2: run_bytes.push_back(HDR_END3);
                    1: run_bytes.push_back(HDR_END2);
                    0: run_bytes.push_back(HDR_END1);
                    default: run_bytes.push_back(HDR_CONT);
                endcase
                slot = 2'd1;
            end
            if (remaining == 0) begin
                run_bytes.push_back(BYTE_EOX);
                slot++;
                while (slot != 2'd0) begin
                    run_bytes.push_back(BYTE_PAD);
                    slot++;
                end
                ended = 1'b1;
            end
            foreach (run_bytes[i]) begin
                e.out_byte    = run_bytes[i];
                e.run_last    = (i == run_bytes.size() - 1);
                e.message_end = ended && e.run_last;
                expected_q.push_back(e);
            end
        endfunction

        function void check_result(input logic [7:0] out_byte, input logic run_last,
                                   input logic message_end);
            t_stream_byte e;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: byte %02h last %0b end %0b",
                             out_byte, run_last, message_end);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (e.out_byte !== out_byte || e.run_last !== run_last ||
                e.message_end !== message_end) begin
                if (mismatches < 10)
                    $display("mismatch: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                             e.out_byte, e.run_last, e.message_end,
                             out_byte, run_last, message_end);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [UMSP_CFG_W-1:0] cfg_wdata;
    int unsigned           burst_left;
    int unsigned           hold_reqs = 0;
    sysex_scoreboard       sb;

    umsp_in_if  in_if ();
    umsp_out_if out_if ();

    usb_midi_sysex_packetizer_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_byte(input logic [7:0] value);
        in_if.valid     <= 1'b1;
        in_if.data_byte <= value;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        sb.note_request(value);
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_stream_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [UMSP_CFG_W-1:0] value);
        wait_stream_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_length(value);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input logic [UMSP_CFG_W-1:0] len, input int unsigned n,
                                input bit hold);
        write_length(len);
        if (hold)
            hold_reqs <= hold_reqs + 1;
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin : receiver
        t_rx_mode    mode;
        int unsigned seg_left;
        int unsigned hold_left;
        int unsigned holds_seen;
        logic [7:0]  pat;
        mode         = RX_FREE;
        seg_left     = 0;
        hold_left    = 0;
        holds_seen   = 0;
        pat          = 8'hFF;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                sb.check_result(out_if.out_byte, out_if.run_last, out_if.message_end);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 2));
                    seg_left = $urandom_range(16, 96);
                    pat      = 8'($urandom);
                end
                seg_left--;
                case (mode)
                    RX_FREE:   out_if.ready <= 1'b1;
                    RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default:   out_if.ready <= pat[seg_left % 8];
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("tb_usb_midi_sysex_packetizer_top: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        sb              = new();
        burst_left      = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one whole message at the length left by reset
        repeat (UMSP_LEN_RST) send_byte(8'($urandom_range(0, 255)));

        // short lengths clamp to two
        write_length(13'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        write_length(13'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        // each end header in turn
        write_length(13'd3);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        write_length(13'd4);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h0F);
        send_byte(8'hF0);
        write_length(13'd5);
        send_byte(8'hF7);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'hFE);
        // length changed mid-message: applies from the next message
        write_length(13'd6);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        write_length(13'd2);
        send_byte(8'h40);
        send_byte(8'h50);
        send_byte(8'h60);
        send_byte(8'h70);
        send_byte(8'h80);

        random_phase(13'd2, 8, 1'b0);
        random_phase(13'($urandom_range(3, 20)), 24, 1'b1);
        random_phase(13'd1, 4, 1'b0);
        random_phase(13'($urandom_range(6, 12)), 12, 1'b0);
        random_phase(13'd0, 4, 1'b0);

        // field maximum clamps to the largest payload; message left open
        random_phase(13'h1FFF, 8, 1'b0);

        wait_stream_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_usb_midi_sysex_packetizer_top: PASS");
        else
            $display("tb_usb_midi_sysex_packetizer_top: FAIL");
        $finish;
    end
endmodule
